[hdl/mcpm_pkg.sv]
// shared types and constants for the multi-click pattern matcher
`timescale 1ns / 1ps

package mcpm_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_STEP_0   = 3'd0;
  localparam logic [2:0] REG_SEQ_LEN  = 3'd6;
  localparam logic [2:0] REG_COOLDOWN = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int ENTRY_W    = 50;
  localparam int SEQ_LEN_W  = 3;
  localparam int STEP_IDX_W = 3;
  localparam int COOL_W     = 24;

  // packed step entry layout
  localparam int ENT_LEVEL_BIT = 0;
  localparam int ENT_NOMAX_BIT = 1;
  localparam int ENT_MIN_LSB   = 2;
  localparam int ENT_MAX_LSB   = 26;

  // one-shot timer slots, handled in this order every tick
  typedef enum logic [1:0] {
    TMR_VALID    = 2'd0,
    TMR_NOTVALID = 2'd1,
    TMR_COOL     = 2'd2,
    TMR_TRIG     = 2'd3
  } timer_id_t;

  localparam int NUM_TIMERS = 4;

  typedef logic [ENTRY_W-1:0] step_entry_t;

  typedef struct packed {
    logic fired;
    logic matching;
    logic cooling_down;
  } result_t;

endpackage

[hdl/multi_click_pattern_matcher.sv]
// multi-click pattern matcher top level: tick-by-tick level sequence match
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_level
//   out_     output     out_valid / out_stall  out_fired, out_matching, out_cooling_down
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one tick is accepted per cycle while in_stall is low; its result is registered.
// the whole tick update (level change, then the four timers in order) is one pass of
// logic ahead of the state and result registers.
// a two-entry output (result register plus skid register) keeps taking ticks while a
// result waits; in_stall rises only when both entries are full.
// rst_n is synchronous; reset clears all state, timers and configuration to their defaults.
`timescale 1ns / 1ps

module multi_click_pattern_matcher #(
  parameter int MAX_STEPS = 6,
  parameter int TIME_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_fired,
  output logic                              out_matching,
  output logic                              out_cooling_down,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcpm_pkg::ENTRY_W-1:0]      cfg_data
);

  localparam logic [mcpm_pkg::SEQ_LEN_W-1:0] MaxLen = mcpm_pkg::SEQ_LEN_W'(MAX_STEPS);
  localparam int TV = int'(mcpm_pkg::TMR_VALID);
  localparam int TN = int'(mcpm_pkg::TMR_NOTVALID);
  localparam int TC = int'(mcpm_pkg::TMR_COOL);
  localparam int TT = int'(mcpm_pkg::TMR_TRIG);

  // configuration
  mcpm_pkg::step_entry_t               entry_r [MAX_STEPS];
  logic [mcpm_pkg::SEQ_LEN_W-1:0]      seq_len_r;
  logic [TIME_BITS-1:0]                cool_ticks_r;

  // match state
  logic                                prev_level_r, prev_level_nxt;
  logic                                active_r, active_nxt;
  logic [mcpm_pkg::STEP_IDX_W-1:0]     step_r, step_nxt;
  logic                                timing_ok_r, timing_ok_nxt;
  logic                                cool_flag_r, cool_flag_nxt;
  logic [TIME_BITS-1:0]                cnt_r   [mcpm_pkg::NUM_TIMERS];
  logic [TIME_BITS-1:0]                cnt_nxt [mcpm_pkg::NUM_TIMERS];
  logic [mcpm_pkg::NUM_TIMERS-1:0]     run_r, run_nxt;

  // output register and skid
  logic                                out_valid_r, skid_valid_r;
  mcpm_pkg::result_t                   out_r, skid_r, res;

  logic                                accept;
  logic [mcpm_pkg::SEQ_LEN_W-1:0]      n_len;
  mcpm_pkg::step_entry_t               cur_entry;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;

  assign out_valid        = out_valid_r;
  assign out_fired        = out_r.fired;
  assign out_matching     = out_r.matching;
  assign out_cooling_down = out_r.cooling_down;

  // effective sequence length, clamped to 1..MAX_STEPS
  always_comb begin
    if (seq_len_r == '0) begin
      n_len = mcpm_pkg::SEQ_LEN_W'(1);
    end else if (seq_len_r > MaxLen) begin
      n_len = MaxLen;
    end else begin
      n_len = seq_len_r;
    end
  end

  // entry of the step being waited for
  always_comb begin
    cur_entry = '0;
    for (int k = 0; k < MAX_STEPS; k++) begin
      if (step_r == mcpm_pkg::STEP_IDX_W'(k)) cur_entry = entry_r[k];
    end
  end

  // one tick: level change first, then the timers in order
  always_comb begin
    logic                 lv_e0, nomax_e0, nomax_ci;
    logic [TIME_BITS-1:0] min_e0, max_e0, min_ci, max_ci;
    logic                 fired;

    lv_e0    = entry_r[0][mcpm_pkg::ENT_LEVEL_BIT];
    nomax_e0 = entry_r[0][mcpm_pkg::ENT_NOMAX_BIT];
    min_e0   = entry_r[0][mcpm_pkg::ENT_MIN_LSB +: TIME_BITS];
    max_e0   = entry_r[0][mcpm_pkg::ENT_MAX_LSB +: TIME_BITS];
    nomax_ci = cur_entry[mcpm_pkg::ENT_NOMAX_BIT];
    min_ci   = cur_entry[mcpm_pkg::ENT_MIN_LSB +: TIME_BITS];
    max_ci   = cur_entry[mcpm_pkg::ENT_MAX_LSB +: TIME_BITS];
    fired    = 1'b0;

    prev_level_nxt = prev_level_r;
    active_nxt     = active_r;
    step_nxt       = step_r;
    timing_ok_nxt  = timing_ok_r;
    cool_flag_nxt  = cool_flag_r;
    run_nxt        = run_r;
    for (int t = 0; t < mcpm_pkg::NUM_TIMERS; t++) cnt_nxt[t] = cnt_r[t];

    if (in_level != prev_level_r) begin
      prev_level_nxt = in_level;
      if (!cool_flag_r) begin
        if (!active_r) begin
          if (lv_e0 == in_level) begin
            active_nxt = 1'b1;
            step_nxt   = mcpm_pkg::STEP_IDX_W'(1);
            if (n_len == mcpm_pkg::SEQ_LEN_W'(1) && nomax_e0) begin
              cnt_nxt[TT] = min_e0;
              run_nxt[TT] = 1'b1;
            end else begin
              if (min_e0 == '0) begin
                timing_ok_nxt = 1'b1;
              end else begin
                timing_ok_nxt = 1'b0;
                cnt_nxt[TV]   = min_e0;
                run_nxt[TV]   = 1'b1;
              end
              if (!nomax_e0) begin
                cnt_nxt[TN] = max_e0;
                run_nxt[TN] = 1'b1;
              end
            end
          end
        end else if (!timing_ok_r) begin
          // change before the minimum: abort into cooldown
          cool_flag_nxt = 1'b1;
          cnt_nxt[TC]   = cool_ticks_r;
          run_nxt[TC]   = 1'b1;
          active_nxt    = 1'b0;
          step_nxt      = '0;
          run_nxt[TT]   = 1'b0;
          cnt_nxt[TT]   = '0;
          run_nxt[TV]   = 1'b0;
          cnt_nxt[TV]   = '0;
          run_nxt[TN]   = 1'b0;
          cnt_nxt[TN]   = '0;
        end else if (step_r >= n_len) begin
          active_nxt  = 1'b0;
          step_nxt    = '0;
          run_nxt[TT] = 1'b0;
          cnt_nxt[TT] = '0;
          run_nxt[TV] = 1'b0;
          cnt_nxt[TV] = '0;
          run_nxt[TN] = 1'b0;
          cnt_nxt[TN] = '0;
          fired       = 1'b1;
        end else begin
          if (!nomax_ci) begin
            if (min_ci == '0) begin
              timing_ok_nxt = 1'b1;
            end else begin
              timing_ok_nxt = 1'b0;
              cnt_nxt[TV]   = min_ci;
              run_nxt[TV]   = 1'b1;
            end
            cnt_nxt[TN] = max_ci;
            run_nxt[TN] = 1'b1;
          end else if (step_r + mcpm_pkg::STEP_IDX_W'(1) != n_len) begin
            run_nxt[TN] = 1'b0;
            cnt_nxt[TN] = '0;
            if (min_ci == '0) begin
              timing_ok_nxt = 1'b1;
            end else begin
              timing_ok_nxt = 1'b0;
              cnt_nxt[TV]   = min_ci;
              run_nxt[TV]   = 1'b1;
            end
          end else begin
            // last step without maximum: trigger after its minimum
            timing_ok_nxt = 1'b0;
            run_nxt[TN]   = 1'b0;
            cnt_nxt[TN]   = '0;
            cnt_nxt[TT]   = min_ci;
            run_nxt[TT]   = 1'b1;
          end
          step_nxt = step_r + mcpm_pkg::STEP_IDX_W'(1);
        end
      end
    end

    // valid timer
    if (run_nxt[TV]) begin
      if (cnt_nxt[TV] != '0) cnt_nxt[TV] = cnt_nxt[TV] - TIME_BITS'(1);
      if (cnt_nxt[TV] == '0) begin
        run_nxt[TV]   = 1'b0;
        timing_ok_nxt = 1'b1;
      end
    end

    // not-valid timer: waited too long
    if (run_nxt[TN]) begin
      if (cnt_nxt[TN] != '0) cnt_nxt[TN] = cnt_nxt[TN] - TIME_BITS'(1);
      if (cnt_nxt[TN] == '0) begin
        run_nxt[TN]   = 1'b0;
        timing_ok_nxt = 1'b0;
        cool_flag_nxt = 1'b1;
        cnt_nxt[TC]   = cool_ticks_r;
        run_nxt[TC]   = 1'b1;
        active_nxt    = 1'b0;
        step_nxt      = '0;
        run_nxt[TT]   = 1'b0;
        cnt_nxt[TT]   = '0;
        run_nxt[TV]   = 1'b0;
        cnt_nxt[TV]   = '0;
        cnt_nxt[TN]   = '0;
      end
    end

    // cooldown timer
    if (run_nxt[TC]) begin
      if (cnt_nxt[TC] != '0) cnt_nxt[TC] = cnt_nxt[TC] - TIME_BITS'(1);
      if (cnt_nxt[TC] == '0) begin
        run_nxt[TC]   = 1'b0;
        cool_flag_nxt = 1'b0;
      end
    end

    // trigger timer
    if (run_nxt[TT]) begin
      if (cnt_nxt[TT] != '0) cnt_nxt[TT] = cnt_nxt[TT] - TIME_BITS'(1);
      if (cnt_nxt[TT] == '0) begin
        active_nxt  = 1'b0;
        step_nxt    = '0;
        run_nxt[TT] = 1'b0;
        cnt_nxt[TT] = '0;
        run_nxt[TV] = 1'b0;
        cnt_nxt[TV] = '0;
        run_nxt[TN] = 1'b0;
        cnt_nxt[TN] = '0;
        fired       = 1'b1;
      end
    end

    res.fired        = fired;
    res.matching     = active_nxt;
    res.cooling_down = cool_flag_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_STEPS; k++) entry_r[k] <= '0;
      seq_len_r    <= mcpm_pkg::SEQ_LEN_W'(1);
      cool_ticks_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < mcpm_pkg::REG_SEQ_LEN) begin
        for (int k = 0; k < MAX_STEPS; k++) begin
          if (cfg_index == mcpm_pkg::REG_STEP_0 + mcpm_pkg::CFG_IDX_W'(k)) begin
            entry_r[k] <= cfg_data;
          end
        end
      end else if (cfg_index == mcpm_pkg::REG_SEQ_LEN) begin
        seq_len_r <= cfg_data[mcpm_pkg::SEQ_LEN_W-1:0];
      end else if (cfg_index == mcpm_pkg::REG_COOLDOWN) begin
        cool_ticks_r <= cfg_data[TIME_BITS-1:0];
      end
    end
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= 1'b0;
      active_r     <= 1'b0;
      step_r       <= '0;
      timing_ok_r  <= 1'b0;
      cool_flag_r  <= 1'b0;
      run_r        <= '0;
      for (int t = 0; t < mcpm_pkg::NUM_TIMERS; t++) cnt_r[t] <= '0;
    end else if (accept) begin
      prev_level_r <= prev_level_nxt;
      active_r     <= active_nxt;
      step_r       <= step_nxt;
      timing_ok_r  <= timing_ok_nxt;
      cool_flag_r  <= cool_flag_nxt;
      run_r        <= run_nxt;
      for (int t = 0; t < mcpm_pkg::NUM_TIMERS; t++) cnt_r[t] <= cnt_nxt[t];
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

endmodule
